// ===== src/oaht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the open-addressing hash table.
package oaht_pkg;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int HASH_W     = 64;
    localparam int MUL_W      = 32;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [HASH_W-1:0]  HASH_MULT_RESET  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 10'd512;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_MULT  = 1'b0,
        CFG_LOAD_LIMIT = 1'b1
    } cfg_index_t;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_FOUND     = 3'd0;
    localparam status_t ST_INSERTED  = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_CLEARED   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;      // latch key and value, first partial product
        logic    hash_mid;    // second partial product
        logic    hash_late;   // third partial product
        logic    hash_last;   // form the home slot and restart the probe
        logic    probe_next;  // move on to the next slot of the probe sequence
        logic    ins_write;   // write the new entry and bump the count
        logic    clr_start;   // rewind the sweep and zero the count
        logic    clr_write;   // empty one slot and step the sweep
        logic    res_load;    // load the output register
        status_t res_status;
        logic    res_hit;     // result value comes from the stored entry
        logic    res_ins;     // result value comes from the input word
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic at_limit;
        logic clr_last;
    } dp_stat_t;

endpackage

// ===== src/oaht_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module oaht_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/oaht_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the hash table: sequences hashing, probing and clearing.
module oaht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  oaht_pkg::cmd_t     in_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output oaht_pkg::dp_cmd_t  dp_cmd,
    input  oaht_pkg::dp_stat_t dp_stat
);

    import oaht_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_PROBE,
        S_CLEAR,
        S_FIXED
    } state_t;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    logic    out_valid_reg;
    logic    out_free;
    dp_cmd_t dpc;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign dp_cmd   = dpc;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dpc            = '0;
        dpc.res_status = ST_NOT_FOUND;
        case (state_reg)
            S_INIT:
            begin
                dpc.clr_write = 1'b1;
                if (dp_stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_valid)
                begin
                    dpc.accept = 1'b1;
                    cmd_next   = in_cmd;
                    case (in_cmd)
                        CMD_LOOKUP, CMD_ADD:
                        begin
                            state_next = S_HASH1;
                        end
                        CMD_CLEAR:
                        begin
                            dpc.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_FIXED;
                        end
                    endcase
                end
            end
            S_HASH1:
            begin
                dpc.hash_mid = 1'b1;
                state_next   = S_HASH2;
            end
            S_HASH2:
            begin
                dpc.hash_late = 1'b1;
                state_next    = S_HASH3;
            end
            S_HASH3:
            begin
                dpc.hash_last = 1'b1;
                state_next    = S_PROBE;
            end
            S_PROBE:
            begin
                if (dp_stat.slot_valid && !dp_stat.key_match && !dp_stat.last_probe)
                begin
                    dpc.probe_next = 1'b1;
                end
                else if (out_free)
                begin
                    // The outcome is only acted on once the output register can take it,
                    // so an insert never runs ahead of its result word.
                    dpc.res_load = 1'b1;
                    state_next   = S_IDLE;
                    if (!dp_stat.slot_valid)
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            if (dp_stat.at_limit)
                            begin
                                dpc.res_status = ST_FULL;
                            end
                            else
                            begin
                                dpc.ins_write  = 1'b1;
                                dpc.res_ins    = 1'b1;
                                dpc.res_status = ST_INSERTED;
                            end
                        end
                    end
                    else if (dp_stat.key_match)
                    begin
                        dpc.res_hit    = 1'b1;
                        dpc.res_status = ST_FOUND;
                    end
                    else if (cmd_reg == CMD_ADD)
                    begin
                        dpc.res_status = ST_FULL;
                    end
                end
            end
            S_CLEAR:
            begin
                dpc.clr_write = 1'b1;
                if (dp_stat.clr_last)
                begin
                    state_next = S_FIXED;
                end
            end
            S_FIXED:
            begin
                if (out_free)
                begin
                    dpc.res_load   = 1'b1;
                    dpc.res_status = (cmd_reg == CMD_CLEAR) ? ST_CLEARED : ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cmd_reg       <= CMD_LOOKUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            if (dpc.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/oaht_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the hash table: hash multiplier, probe counters, slot memory and result register.
module oaht_dp #(
    parameter int SLOTS       = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  oaht_pkg::dp_cmd_t                   dp_cmd,
    output oaht_pkg::dp_stat_t                  dp_stat,
    input  logic [KEY_WIDTH-1:0]                in_key,
    input  logic [VALUE_WIDTH-1:0]              in_value,
    input  logic                                cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic [oaht_pkg::STATUS_W-1:0]       res_status,
    output logic [VALUE_WIDTH-1:0]              res_value
);

    import oaht_pkg::*;

    localparam int SB    = $clog2(SLOTS);
    localparam int EW    = 1 + KEY_WIDTH + VALUE_WIDTH;
    localparam int HALF  = SLOTS / 2;
    localparam int CNT_W = $clog2(HALF + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    logic [HASH_W-1:0]      hash_mult_reg;
    logic [LIMIT_W-1:0]     load_limit_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [HASH_W-1:0]      prod_reg;
    logic [HASH_W-1:0]      acc_reg;
    logic [SB-1:0]          idx_reg, idx_next;
    logic [SB-1:0]          step_reg;
    logic [SB-1:0]          n_reg;
    logic [CNT_W-1:0]       count_reg;
    status_t                res_status_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;

    logic [HASH_W-1:0]      in_key64, key64;
    logic [MUL_W-1:0]       op_a, op_b;
    logic [2*MUL_W-1:0]     prod_next;
    logic [HASH_W-1:0]      hash_sum;
    logic [EW-1:0]          rd_data, wr_data;
    logic                   ram_we;
    logic [LIM_W-1:0]       count_ext;

    assign in_key64 = HASH_W'(in_key);
    assign key64    = HASH_W'(key_reg);

    // The low 64 bits of key * multiplier from three 32 x 32 partial products;
    // the high-by-high product only affects bits above 64 and is dropped.
    always_comb
    begin
        if (dp_cmd.accept)
        begin
            op_a = in_key64[MUL_W-1:0];
            op_b = hash_mult_reg[MUL_W-1:0];
        end
        else if (dp_cmd.hash_mid)
        begin
            op_a = key64[MUL_W-1:0];
            op_b = hash_mult_reg[HASH_W-1:MUL_W];
        end
        else
        begin
            op_a = key64[HASH_W-1:MUL_W];
            op_b = hash_mult_reg[MUL_W-1:0];
        end
    end

    assign prod_next = op_a * op_b;
    assign hash_sum  = acc_reg + {prod_reg[MUL_W-1:0], {MUL_W{1'b0}}};

    // The read address is the next probe slot, so its entry is ready in the following cycle.
    always_comb
    begin
        idx_next = idx_reg;
        if (dp_cmd.clr_start)
        begin
            idx_next = '0;
        end
        else if (dp_cmd.clr_write)
        begin
            idx_next = idx_reg + SB'(1);
        end
        else if (dp_cmd.hash_last)
        begin
            idx_next = hash_sum[HASH_W-1 -: SB];
        end
        else if (dp_cmd.probe_next)
        begin
            idx_next = idx_reg + step_reg;
        end
    end

    assign ram_we  = dp_cmd.ins_write || dp_cmd.clr_write;
    assign wr_data = dp_cmd.ins_write ? {1'b1, key_reg, value_reg} : '0;

    oaht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_data),
        .raddr (idx_next),
        .rdata (rd_data)
    );

    assign count_ext = LIM_W'(count_reg);

    assign dp_stat.slot_valid = rd_data[EW-1];
    assign dp_stat.key_match  = (rd_data[VALUE_WIDTH +: KEY_WIDTH] == key_reg);
    assign dp_stat.last_probe = (n_reg == SB'(SLOTS - 1));
    assign dp_stat.at_limit   = (count_ext >= LIM_W'(load_limit_reg))
                             || (count_ext >= LIM_W'(HALF));
    assign dp_stat.clr_last   = &idx_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        if (dp_cmd.accept || dp_cmd.hash_mid || dp_cmd.hash_late)
        begin
            prod_reg <= prod_next;
        end
        if (dp_cmd.hash_mid)
        begin
            acc_reg <= prod_reg;
        end
        else if (dp_cmd.hash_late)
        begin
            acc_reg <= hash_sum;
        end
        if (dp_cmd.hash_last)
        begin
            step_reg <= SB'(1);
            n_reg    <= '0;
        end
        else if (dp_cmd.probe_next)
        begin
            step_reg <= step_reg + SB'(1);
            n_reg    <= n_reg + SB'(1);
        end
        if (dp_cmd.res_load)
        begin
            res_status_reg <= dp_cmd.res_status;
            if (dp_cmd.res_hit)
            begin
                res_value_reg <= rd_data[VALUE_WIDTH-1:0];
            end
            else if (dp_cmd.res_ins)
            begin
                res_value_reg <= value_reg;
            end
            else
            begin
                res_value_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            count_reg      <= '0;
            hash_mult_reg  <= HASH_MULT_RESET;
            load_limit_reg <= LOAD_LIMIT_RESET;
        end
        else
        begin
            idx_reg <= idx_next;
            if (dp_cmd.clr_start)
            begin
                count_reg <= '0;
            end
            else if (dp_cmd.ins_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HASH_MULT:  hash_mult_reg  <= cfg_wdata[HASH_W-1:0];
                    CFG_LOAD_LIMIT: load_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    assign res_status = res_status_reg;
    assign res_value  = res_value_reg;

endmodule

// ===== src/open_addressing_hash_table.sv =====
`timescale 1ns / 1ps
// Top level of the open-addressing hash table with triangular probing. Each input word
// carries one command: lookup, add-if-absent or clear; every command gives exactly one
// result word. After reset the block sweeps and empties the whole slot memory before it
// accepts its first word (configuration writes are taken throughout). A lookup or add
// first latches the word, then forms the home slot in the states S_HASH1, S_HASH2 and
// S_HASH3 on a single shared 32 x 32 multiplier, then reads the slot memory once per probed
// slot. A clear makes one memory write per slot; an unused command code gives a not-found
// result. The result waits in an output register, so the next word is accepted while an
// earlier result has not yet been taken.
module open_addressing_hash_table #(
    parameter int SLOTS       = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key, value
    input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic [oaht_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_value
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [oaht_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import oaht_pkg::*;

    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;

    dp_cmd_t                dp_cmd;
    dp_stat_t               dp_stat;
    logic [VALUE_WIDTH-1:0] res_value;

    oaht_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .in_cmd  (cmd_t'(s_axis_tuser)),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    oaht_dp #(
        .SLOTS       (SLOTS),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .in_key     (s_axis_tdata[KEY_WIDTH-1:0]),
        .in_value   (s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .res_status (m_axis_tuser),
        .res_value  (res_value)
    );

    assign m_axis_tdata = OUT_W'(res_value);

endmodule

// ===== src/oaht_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the hash table and its binding to the top level.
module oaht_checker #(
    parameter int DATA_W = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [DATA_W-1:0]             m_axis_tdata,
    input logic [oaht_pkg::STATUS_W-1:0] m_axis_tuser
);

    import oaht_pkg::*;

    // A result word that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Misses, full reports and clears carry a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL
                          || m_axis_tuser == ST_CLEARED)
        |-> m_axis_tdata == '0)
        else $error("non-zero value with a miss, full or cleared status");

    // One command at a time: the block is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // No command completes in the cycle right after it was taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early after an accept");

endmodule

bind open_addressing_hash_table oaht_checker #(
    .DATA_W (OUT_W)
) u_oaht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
